### hdl/dsv_pkg.sv
// Shared constants, types and calendar helpers for the date string validator.
`default_nettype none
package dsv_pkg;

  localparam int CHAR_W  = 8;
  localparam int DAY_W   = 7;
  localparam int MONTH_W = 7;
  localparam int YACC_W  = 14;
  localparam int YEAR_W  = 15;
  localparam int FIELD_W = 2;
  localparam int DCNT_W  = 3;
  localparam int MLEN_W  = 5;

  localparam logic [CHAR_W-1:0] SLASH_CODE = 8'h2F;
  localparam logic [CHAR_W-1:0] ZERO_CODE  = 8'h30;
  localparam logic [CHAR_W-1:0] NINE_CODE  = 8'h39;

  localparam logic [YACC_W-1:0] YEAR_BASE_RESET = 14'd2000;

  localparam logic [FIELD_W-1:0] FIELD_DAY   = 2'd0;
  localparam logic [FIELD_W-1:0] FIELD_MONTH = 2'd1;
  localparam logic [FIELD_W-1:0] FIELD_YEAR  = 2'd2;

  localparam logic [DCNT_W-1:0] DAY_DIGITS   = 3'd2;
  localparam logic [DCNT_W-1:0] MONTH_DIGITS = 3'd2;
  localparam logic [DCNT_W-1:0] YEAR_DIGITS  = 3'd4;

  // n divisible by 25 iff (n * inv(25) mod 2^15) <= floor((2^15 - 1) / 25)
  localparam logic [YEAR_W-1:0] INV25       = 15'd23593;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 15'd1310;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YACC_W-1:0]  year_raw;
    logic               fmt_ok;
  } parse_res_t;

  function automatic logic [MLEN_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
    logic [MLEN_W-1:0] len;
    unique case (month)
      7'd2:                                 len = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:              len = 5'd30;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10,
      7'd12:                                len = 5'd31;
      default:                              len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

### hdl/dsv_char_if.sv
// Character stream channel: one text character per transaction.
`default_nettype none
interface dsv_char_if;
  import dsv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface
`default_nettype wire

### hdl/dsv_date_if.sv
// Result channel: validity flag and parsed date fields per transaction.
`default_nettype none
interface dsv_date_if;
  import dsv_pkg::*;

  logic               valid;
  logic               ready;
  logic               date_valid;
  logic [DAY_W-1:0]   day_value;
  logic [MONTH_W-1:0] month_value;
  logic [YEAR_W-1:0]  year_value;

  modport source (output valid, output date_valid, output day_value, output month_value,
                  output year_value, input ready);
  modport sink   (input valid, input date_valid, input day_value, input month_value,
                  input year_value, output ready);
endinterface
`default_nettype wire

### hdl/dsv_parser.sv
// Character parser: accumulates day, month and year fields and tracks format errors.
`default_nettype none
module dsv_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      take,
  input  wire logic [dsv_pkg::CHAR_W-1:0] char_code,
  input  wire logic                      is_last,
  output dsv_pkg::parse_res_t            res
);
  import dsv_pkg::*;

  logic [FIELD_W-1:0] field_r, field_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YACC_W-1:0]  year_r, year_nxt;
  logic [DCNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic               err_r, err_nxt;

  logic               is_slash;
  logic               is_digit;
  logic [3:0]         digit;
  logic [DCNT_W-1:0]  limit;

  assign is_slash = (char_code == SLASH_CODE);
  assign is_digit = (char_code >= ZERO_CODE) && (char_code <= NINE_CODE);
  assign digit    = char_code[3:0];
  assign limit    = (field_r == FIELD_YEAR) ? YEAR_DIGITS :
                    (field_r == FIELD_MONTH) ? MONTH_DIGITS : DAY_DIGITS;

  always_comb begin
    field_nxt = field_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    dcnt_nxt  = dcnt_r;
    err_nxt   = err_r;
    if (is_slash) begin
      if (field_r >= FIELD_YEAR) begin
        err_nxt = 1'b1;
      end else begin
        if (dcnt_r == '0) begin
          err_nxt = 1'b1;
        end
        field_nxt = field_r + FIELD_W'(1);
        dcnt_nxt  = '0;
      end
    end else if (is_digit) begin
      if (field_r > FIELD_YEAR || dcnt_r >= limit) begin
        err_nxt = 1'b1;
      end else begin
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        priority if (field_r == FIELD_DAY) begin
          day_nxt = {day_r[DAY_W-4:0], 3'b000} + {day_r[DAY_W-2:0], 1'b0}
                    + DAY_W'(digit);
        end else if (field_r == FIELD_MONTH) begin
          month_nxt = {month_r[MONTH_W-4:0], 3'b000} + {month_r[MONTH_W-2:0], 1'b0}
                      + MONTH_W'(digit);
        end else begin
          year_nxt = {year_r[YACC_W-4:0], 3'b000} + {year_r[YACC_W-2:0], 1'b0}
                     + YACC_W'(digit);
        end
      end
    end else begin
      err_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && is_last)) begin
      field_r <= FIELD_DAY;
      day_r   <= '0;
      month_r <= '0;
      year_r  <= '0;
      dcnt_r  <= '0;
      err_r   <= 1'b0;
    end else if (take) begin
      field_r <= field_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      dcnt_r  <= dcnt_nxt;
      err_r   <= err_nxt;
    end
  end

  assign res.day      = day_nxt;
  assign res.month    = month_nxt;
  assign res.year_raw = year_nxt;
  assign res.fmt_ok   = !err_nxt && (field_nxt == FIELD_YEAR) && (dcnt_nxt != '0);

endmodule
`default_nettype wire

### hdl/date_string_validator.sv
// Date string validator top level: dd/mm/yyyy text in, Gregorian validity and fields out.
// Takes one character per cycle while in_ch.ready is high; the result for a text leaves
// the output register after its last character's transaction has passed the parse snapshot,
// year adjust and calendar check stages. Throughput is one character per cycle while out_date drains.
// Synchronous active-low reset clears the parse state, the pipeline and sets base_r to 2000.
`default_nettype none
module date_string_validator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [dsv_pkg::YACC_W-1:0]  cfg_wdata,
  dsv_char_if.sink                         in_ch,
  dsv_date_if.source                       out_date
);
  import dsv_pkg::*;

  logic [YACC_W-1:0]  base_r;

  parse_res_t         pres;
  logic               take;

  logic               s1_v_r;
  parse_res_t         s1_r;

  logic               s2_v_r;
  logic [DAY_W-1:0]   s2_day_r;
  logic [MONTH_W-1:0] s2_month_r;
  logic [YEAR_W-1:0]  s2_year_r;
  logic               s2_ok_r;
  logic [YEAR_W-1:0]  year_adj;

  logic               out_v_r;
  logic               out_ok_r;
  logic [DAY_W-1:0]   out_day_r;
  logic [MONTH_W-1:0] out_month_r;
  logic [YEAR_W-1:0]  out_year_r;

  logic               out_load;
  logic               s2_free;
  logic               s1_free;

  logic [YEAR_W-1:0]  yprod;
  logic               div4, div16, div25, leap;
  logic [MLEN_W-1:0]  mlen;
  logic               date_ok;

  assign out_load    = !out_v_r || out_date.ready;
  assign s2_free     = !s2_v_r || out_load;
  assign s1_free     = !s1_v_r || s2_free;
  assign in_ch.ready = s1_free;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= YEAR_BASE_RESET;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  dsv_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_code (in_ch.char_code),
    .is_last   (in_ch.is_last),
    .res       (pres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= take && in_ch.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && take && in_ch.is_last) begin
      s1_r <= pres;
    end
  end

  assign year_adj = (s1_r.year_raw < base_r) ?
                    ({1'b0, s1_r.year_raw} + {1'b0, base_r}) : {1'b0, s1_r.year_raw};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_v_r) begin
      s2_day_r   <= s1_r.day;
      s2_month_r <= s1_r.month;
      s2_year_r  <= year_adj;
      s2_ok_r    <= s1_r.fmt_ok;
    end
  end

  assign yprod   = s2_year_r * INV25;
  assign div4    = (s2_year_r[1:0] == 2'b00);
  assign div16   = (s2_year_r[3:0] == 4'b0000);
  assign div25   = (yprod <= DIV25_LIMIT);
  assign leap    = div4 && (!div25 || div16);
  assign mlen    = month_length(s2_month_r, leap);
  assign date_ok = s2_ok_r && (mlen != '0) && (s2_day_r != '0)
                   && ({2'b00, mlen} >= s2_day_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_v_r) begin
      out_ok_r    <= date_ok;
      out_day_r   <= s2_day_r;
      out_month_r <= s2_month_r;
      out_year_r  <= s2_year_r;
    end
  end

  assign out_date.valid       = out_v_r;
  assign out_date.date_valid  = out_ok_r;
  assign out_date.day_value   = out_day_r;
  assign out_date.month_value = out_month_r;
  assign out_date.year_value  = out_year_r;

  a_last_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_ch.is_last |=> s1_v_r)
    else $error("last character transaction did not reach snapshot stage");

  a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_ok_r |-> out_day_r != '0 && out_month_r != '0 && out_month_r <= 7'd12)
    else $error("valid date with out-of-range day or month");

  a_feb29_leap: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_ok_r && out_month_r == 7'd2 && out_day_r == 7'd29
    |-> out_year_r[1:0] == 2'b00)
    else $error("February 29 accepted in a year not divisible by 4");

  a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_load |=> s2_v_r && $stable(s2_year_r))
    else $error("stalled calendar stage lost its transaction");

endmodule
`default_nettype wire
